// File: hw/rtl/med_pkg.sv
// ----------------------------------------------------------------------------
// med_pkg
// Shared widths, register codes, pipeline control type and the 2^-x table
// for the multi-exponential decay evaluator.
// ----------------------------------------------------------------------------
package med_pkg;

	localparam int N_COMPONENTS_DEF = 4;
	localparam int TIME_BITS_DEF    = 16;

	localparam int AMP_W      = 24;
	localparam int RATE_W     = 20;
	localparam int TERM_W     = 24;
	localparam int OUT_W      = 26;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	localparam int LOG2E_W = 31;
	localparam logic [LOG2E_W-1:0] LOG2E_Q30 = 31'h5C551D95;

	localparam int TAB_W      = 25;
	localparam int TAB_IDX_W  = 10;
	localparam int TAB_SIZE   = 1 << TAB_IDX_W;
	localparam int SHIFT_W    = 5;
	localparam int SHIFT_MAX  = 24;
	localparam int Y_IDX_LO   = 20;
	localparam int Y_INT_LO   = 30;
	localparam int PROD_LO    = 24;

	localparam int NUM_STAGES = 7;

	localparam logic [CFG_IDX_W-1:0] REG_AMP_0  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_0 = 4'd4;

	localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
	} pipe_ctl_t;

	typedef logic [TAB_W-1:0] exp_tab_t [TAB_SIZE];

	function automatic logic [63:0] mul_hi64(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[127:64];
	endfunction

	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [5:0] den);
		logic [63:0] q;
		logic [6:0]  r;
		q = '0;
		r = '0;
		for (int k = 63; k >= 0; k--) begin
			r = {r[5:0], num[k]};
			if (r >= {1'b0, den}) begin
				r    = r - {1'b0, den};
				q[k] = 1'b1;
			end
		end
		return q;
	endfunction

	// 2^(-j/1024) in Q1.24, rounded to nearest, from a Taylor series of 1 - exp(-x)
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t    tab;
		logic [63:0] lhi;
		logic [63:0] llo;
		logic [63:0] jj;
		logic [63:0] x;
		logic [63:0] t;
		logic [63:0] d;
		logic [63:0] v;
		lhi = LN2_Q64 >> 10;
		llo = LN2_Q64 & 64'd1023;
		for (int j = 0; j < TAB_SIZE; j++) begin
			jj = 64'(j);
			x  = jj * lhi + ((jj * llo) >> 10);
			t  = x;
			d  = x;
			for (int n = 2; n < 40; n++) begin
				if (t != 64'd0) begin
					t = udiv64(mul_hi64(t, x), 6'(n));
					if ((n & 1) != 0) begin
						d = d + t;
					end else begin
						d = d - t;
					end
				end
			end
			if (d <= (64'd1 << 39)) begin
				tab[j] = TAB_W'(64'd1 << 24);
			end else begin
				v      = ((64'd0 - d) + (64'd1 << 39)) >> 40;
				tab[j] = v[TAB_W-1:0];
			end
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// File: hw/rtl/med_stream_if.sv
// ----------------------------------------------------------------------------
// med_stream_if
// Valid/ready channels: time requests in, decay results out.
// ----------------------------------------------------------------------------
interface med_time_if #(
	parameter int TIME_BITS = med_pkg::TIME_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [TIME_BITS-1:0] time_value;

	modport source (output valid, output time_value, input ready);
	modport sink   (input valid, input time_value, output ready);
endinterface

interface med_decay_if;
	logic                              valid;
	logic                              ready;
	logic signed [med_pkg::OUT_W-1:0]  decay_value;

	modport source (output valid, output decay_value, input ready);
	modport sink   (input valid, input decay_value, output ready);
endinterface

// File: hw/rtl/multi_exponential_decay_eval.sv
// ----------------------------------------------------------------------------
// multi_exponential_decay_eval
// Evaluates f(t) = sum of amp_i * exp(-rate_i * t) over the components.
//
// Requests arrive on sample (time_value, unsigned bins); results leave on
// decay (decay_value, signed Q10.16), one per request, in order.
// Amplitudes (index 0..3, signed Q8.16) and rates (index 4..7, Q0.20 per
// bin) are written through cfg_we/cfg_index/cfg_data; other indexes are
// dropped. The user must write these registers only while no request is
// in flight; the block itself does not enforce this. An accepted request
// reaches its valid result through rate multiply, log2(e) multiply,
// exponent add, table read, shift, amplitude multiply, component sum, one register each.
// Throughput is one request per cycle while decay does not stall.
// Reset clears the amplitude, rate and valid registers to zero, emptying the pipeline.
// When decay stalls, the full stages hold; empty stages ahead of a stalled
// one keep filling, so sample stays ready until the pipeline is full.
// ----------------------------------------------------------------------------
module multi_exponential_decay_eval #(
	parameter int N_COMPONENTS = med_pkg::N_COMPONENTS_DEF,
	parameter int TIME_BITS    = med_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	med_time_if.sink                           sample,
	med_decay_if.source                        decay,
	input  logic                               cfg_we,
	input  logic [med_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [med_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int NS = med_pkg::NUM_STAGES;

	logic signed [med_pkg::AMP_W-1:0]  amp_q  [N_COMPONENTS];
	logic [med_pkg::RATE_W-1:0]        rate_q [N_COMPONENTS];
	logic signed [med_pkg::TERM_W-1:0] term   [N_COMPONENTS];
	logic [NS-1:0]                     vld_q;
	med_pkg::pipe_ctl_t                ctl;

	for (genvar i = 0; i < N_COMPONENTS; i++) begin : g_cfg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				amp_q[i]  <= '0;
				rate_q[i] <= '0;
			end else if (cfg_we) begin
				if (cfg_index == med_pkg::REG_AMP_0 + med_pkg::CFG_IDX_W'(i)) begin
					amp_q[i] <= cfg_data[med_pkg::AMP_W-1:0];
				end
				if (cfg_index == med_pkg::REG_RATE_0 + med_pkg::CFG_IDX_W'(i)) begin
					rate_q[i] <= cfg_data[med_pkg::RATE_W-1:0];
				end
			end
		end

		med_lane #(
			.TIME_BITS (TIME_BITS)
		) u_lane (
			.clk        (clk),
			.ctl        (ctl),
			.time_value (sample.time_value),
			.amp        (amp_q[i]),
			.rate       (rate_q[i]),
			.term       (term[i])
		);
	end

	// advance a stage when it is empty or the one after it advances
	always_comb begin
		ctl.en[NS-1] = !vld_q[NS-1] || decay.ready;
		for (int k = NS - 2; k >= 0; k--) begin
			ctl.en[k] = !vld_q[k] || ctl.en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ctl.en[0]) begin
				vld_q[0] <= sample.valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (ctl.en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	med_sum #(
		.N_COMPONENTS (N_COMPONENTS)
	) u_sum (
		.clk  (clk),
		.ctl  (ctl),
		.term (term),
		.sum  (decay.decay_value)
	);

	assign sample.ready = ctl.en[0];
	assign decay.valid  = vld_q[NS-1];

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!decay.valid |-> sample.ready)
		else $error("sample not ready with an empty output stage");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> vld_q[0])
		else $error("accepted request missing from the first stage");

	a_drain_last: assert property (@(posedge clk) disable iff (!arst_n)
		(decay.valid && decay.ready && !vld_q[NS-2]) |=> !decay.valid)
		else $error("result repeated after it was taken");

endmodule

// File: hw/rtl/med_lane.sv
// ----------------------------------------------------------------------------
// med_lane
// One decay component: rate * t, scale by log2(e), 2^-y table lookup and
// shift, then amplitude product floored to Q8.16. Stages 1 to 6.
// ----------------------------------------------------------------------------
module med_lane #(
	parameter int TIME_BITS = med_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  med_pkg::pipe_ctl_t                 ctl,
	input  logic [TIME_BITS-1:0]               time_value,
	input  logic signed [med_pkg::AMP_W-1:0]   amp,
	input  logic [med_pkg::RATE_W-1:0]         rate,
	output logic signed [med_pkg::TERM_W-1:0]  term
);

	localparam int P_W   = med_pkg::RATE_W + TIME_BITS;
	localparam int A_W   = TIME_BITS + med_pkg::LOG2E_W;
	localparam int B_W   = med_pkg::RATE_W + med_pkg::LOG2E_W;
	localparam int Y_W   = A_W + 1;
	localparam int IP_W  = Y_W - med_pkg::Y_INT_LO;
	localparam int PRD_W = med_pkg::AMP_W + med_pkg::TAB_W + 1;

	logic [P_W-1:0]                      p_s1;
	logic [A_W-1:0]                      a_s2;
	logic [B_W-1:0]                      b_s2;
	logic [med_pkg::TAB_IDX_W-1:0]       idx_s3;
	logic [med_pkg::SHIFT_W-1:0]         sh_s3;
	logic                                zero_s3;
	logic [med_pkg::TAB_W-1:0]           tab_s4;
	logic [med_pkg::SHIFT_W-1:0]         sh_s4;
	logic                                zero_s4;
	logic [med_pkg::TAB_W-1:0]           e_s5;
	logic signed [med_pkg::TERM_W-1:0]   term_s6;

	logic [Y_W-1:0]                      y_sum;
	logic [IP_W-1:0]                     ip;
	logic signed [PRD_W-1:0]             prod;

	always_comb begin
		y_sum = {1'b0, a_s2} + Y_W'(b_s2[B_W-1:med_pkg::RATE_W]);
		ip    = y_sum[Y_W-1:med_pkg::Y_INT_LO];
		prod  = amp * $signed({1'b0, e_s5});
	end

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			p_s1 <= P_W'(rate) * P_W'(time_value);
		end
		if (ctl.en[1]) begin
			a_s2 <= A_W'(p_s1[P_W-1:med_pkg::RATE_W]) * A_W'(med_pkg::LOG2E_Q30);
			b_s2 <= B_W'(p_s1[med_pkg::RATE_W-1:0]) * B_W'(med_pkg::LOG2E_Q30);
		end
		if (ctl.en[2]) begin
			idx_s3  <= y_sum[med_pkg::Y_IDX_LO +: med_pkg::TAB_IDX_W];
			sh_s3   <= ip[med_pkg::SHIFT_W-1:0];
			zero_s3 <= ip > IP_W'(med_pkg::SHIFT_MAX);
		end
		if (ctl.en[3]) begin
			tab_s4  <= med_pkg::EXP_TAB[idx_s3];
			sh_s4   <= sh_s3;
			zero_s4 <= zero_s3;
		end
		if (ctl.en[4]) begin
			e_s5 <= zero_s4 ? '0 : (tab_s4 >> sh_s4);
		end
		if (ctl.en[5]) begin
			term_s6 <= prod[med_pkg::PROD_LO +: med_pkg::TERM_W];
		end
	end

	assign term = term_s6;

endmodule

// File: hw/rtl/med_sum.sv
// ----------------------------------------------------------------------------
// med_sum
// Exact sum of the component terms into the Q10.16 result register.
// ----------------------------------------------------------------------------
module med_sum #(
	parameter int N_COMPONENTS = med_pkg::N_COMPONENTS_DEF
) (
	input  logic                               clk,
	input  med_pkg::pipe_ctl_t                 ctl,
	input  logic signed [med_pkg::TERM_W-1:0]  term [N_COMPONENTS],
	output logic signed [med_pkg::OUT_W-1:0]   sum
);

	logic signed [med_pkg::OUT_W-1:0] acc;
	logic signed [med_pkg::OUT_W-1:0] sum_s7;

	always_comb begin
		acc = '0;
		for (int i = 0; i < N_COMPONENTS; i++) begin
			acc = acc + med_pkg::OUT_W'(term[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[med_pkg::NUM_STAGES-1]) begin
			sum_s7 <= acc;
		end
	end

	assign sum = sum_s7;

endmodule
